FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/swc_pkg.sv
// Types, constants and helper functions of the wall crossing check.
// No dependencies; imported by the cell, the top level and the checker.
package swc_pkg;

    localparam int MAX_WALLS_DEF = 64;
    localparam int COORD_W       = 16;
    localparam int FIRST_W       = 6;
    localparam int COUNT_W       = 7;
    localparam int IN_TDATA_W    = 4 * COORD_W;
    localparam int OUT_TDATA_W   = 16;
    localparam int CROSS_W       = 2 * (COORD_W + 1) + 1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    // One segment: a wall or a move, two end points in the x-z plane.
    typedef struct packed {
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] ax;
    } t_seg;

    // Query item walking down the row of cells.
    typedef struct packed {
        logic valid;
        logic found;
        t_seg seg;
    } t_token;

    // Wall write broadcast to the cells.
    typedef struct packed {
        logic en;
        t_seg seg;
    } t_wr;

    // True when the two cross products do not lie strictly on the same side.
    function automatic logic f_straddle(input logic signed [CROSS_W-1:0] a,
                                        input logic signed [CROSS_W-1:0] b);
        f_straddle = (a == '0) || (b == '0) || (a[CROSS_W-1] ^ b[CROSS_W-1]);
    endfunction

endpackage

FILE: sv/swc_cell.sv
// One cell of the wall row: holds one wall and tests the passing query.
// Depends on swc_pkg.
module swc_cell
    import swc_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int IW        = 6,
    parameter int CW        = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_wr           i_wr,
    input  logic [IW-1:0] i_wr_idx,
    input  logic [CW-1:0] i_count,
    input  t_token        i_tok,
    input  logic [IW-1:0] i_first,
    output t_token        o_tok,
    output logic [IW-1:0] o_first
);

    localparam logic [IW-1:0] IDX_I = IW'(IDX);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    t_seg   r_wall;
    t_token r_tok;
    logic [IW-1:0] r_first;

    logic signed [COORD_W:0]   mx, mz, wx, wz;
    logic signed [COORD_W:0]   e1x, e1z, e2x, e2z, fbx, fbz, fax, faz;
    logic signed [2*COORD_W+1:0] p1a, p1b, p2a, p2b, p3a, p3b, p4a, p4b;
    logic signed [CROSS_W-1:0] d1, d2, d3, d4;
    logic cell_used, hit;
    t_token n_tok;
    logic [IW-1:0] n_first;

    // Differences, all exact in 17 bits.
    always_comb begin
        mx  = {i_tok.seg.bx[COORD_W-1], i_tok.seg.bx} - {i_tok.seg.ax[COORD_W-1], i_tok.seg.ax};
        mz  = {i_tok.seg.bz[COORD_W-1], i_tok.seg.bz} - {i_tok.seg.az[COORD_W-1], i_tok.seg.az};
        wx  = {r_wall.bx[COORD_W-1], r_wall.bx} - {r_wall.ax[COORD_W-1], r_wall.ax};
        wz  = {r_wall.bz[COORD_W-1], r_wall.bz} - {r_wall.az[COORD_W-1], r_wall.az};
        e1x = {r_wall.ax[COORD_W-1], r_wall.ax} - {i_tok.seg.ax[COORD_W-1], i_tok.seg.ax};
        e1z = {r_wall.az[COORD_W-1], r_wall.az} - {i_tok.seg.az[COORD_W-1], i_tok.seg.az};
        e2x = {r_wall.bx[COORD_W-1], r_wall.bx} - {i_tok.seg.ax[COORD_W-1], i_tok.seg.ax};
        e2z = {r_wall.bz[COORD_W-1], r_wall.bz} - {i_tok.seg.az[COORD_W-1], i_tok.seg.az};
        fbx = {i_tok.seg.bx[COORD_W-1], i_tok.seg.bx} - {r_wall.ax[COORD_W-1], r_wall.ax};
        fbz = {i_tok.seg.bz[COORD_W-1], i_tok.seg.bz} - {r_wall.az[COORD_W-1], r_wall.az};
        fax = -e1x;
        faz = -e1z;
    end

    // Four cross products; the move against the wall ends, the wall against the move ends.
    always_comb begin
        p1a = mx * e1z;
        p1b = mz * e1x;
        p2a = mx * e2z;
        p2b = mz * e2x;
        p3a = wx * fbz;
        p3b = wz * fbx;
        p4a = wx * faz;
        p4b = wz * fax;
        d1  = {p1a[2*COORD_W+1], p1a} - {p1b[2*COORD_W+1], p1b};
        d2  = {p2a[2*COORD_W+1], p2a} - {p2b[2*COORD_W+1], p2b};
        d3  = {p3a[2*COORD_W+1], p3a} - {p3b[2*COORD_W+1], p3b};
        d4  = {p4a[2*COORD_W+1], p4a} - {p4b[2*COORD_W+1], p4b};
        hit = f_straddle(d1, d2) && f_straddle(d3, d4);
    end

    // The first used cell that is hit marks the query; later cells leave it alone.
    always_comb begin
        cell_used = (IDX_C < i_count);
        n_tok     = i_tok;
        n_first   = i_first;
        if (i_tok.valid && !i_tok.found && cell_used && hit) begin
            n_tok.found = 1'b1;
            n_first     = IDX_I;
        end
    end

    // Token register toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.found <= n_tok.found;
        r_tok.seg   <= n_tok.seg;
        r_first     <= n_first;
    end

    // Wall register, written when the load addresses this cell.
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr_idx == IDX_I)) begin
            r_wall <= i_wr.seg;
        end
    end

    assign o_tok   = r_tok;
    assign o_first = r_first;

endmodule

FILE: sv/segment_wall_crossing_check.sv
// Top level of the wall crossing check: command decode, wall count, cell row, result register.
// Depends on swc_pkg and swc_cell.
//
// Use: one item on the slave stream is one command, chosen by s_axis_tuser:
// clear the wall table, load one wall (ax,az)-(bx,bz), or query a move from
// (ax,az) to (bx,bz). Each item gives exactly one result item on the master
// stream: crossed, first_wall and wall_count in m_axis_tdata, and the
// table-full status of a rejected load in m_axis_tuser.
// Walls sit in a row of MAX_WALLS cells. A query enters the first cell and
// moves one cell per cycle, so each cell tests its own wall in turn.
// A clear or load result passes the done state into the output register. A
// query token passes the injection register and every cell register, and
// its result then passes the done state into the output register. A new
// item is taken only in the idle state, once the last result is in there.
// Reset empties the table (count zero) and drops any pending result.
// When the receiver stalls, the result waits in the output register; the
// block then finishes at most the current item and holds it until the
// output register is free.
module segment_wall_crossing_check
    import swc_pkg::*;
#(
    parameter int MAX_WALLS = MAX_WALLS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // ax, az, bx, bz (16 bits each)
    input  logic [1:0]             s_axis_tuser,  // command
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // crossed, first_wall[6], wall_count[7], pad
    output logic                   m_axis_tuser   // status
);

    localparam int IW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CW = $clog2(MAX_WALLS + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_WALLS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    t_token        r_inj;
    logic          r_res_crossed;
    logic [IW-1:0] r_res_first;
    logic          r_res_status;
    logic          r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;
    logic          r_m_tuser;

    t_state        n_state;
    logic [CW-1:0] n_count;
    t_token        n_inj;
    logic          n_res_crossed;
    logic [IW-1:0] n_res_first;
    logic          n_res_status;
    logic          n_m_valid;
    logic [OUT_TDATA_W-1:0] n_m_tdata;
    logic          n_m_tuser;

    logic   accept;
    logic   full;
    t_cmd   cmd;
    t_seg   in_seg;
    t_wr    wr;
    t_token        w_tok   [MAX_WALLS+1];
    logic [IW-1:0] w_first [MAX_WALLS+1];

    // Input decode.
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cmd           = t_cmd'(s_axis_tuser);
    assign in_seg        = t_seg'(s_axis_tdata);
    assign full          = (r_count >= MAX_C);

    // Wall write broadcast; the cell whose index equals the count takes it.
    assign wr.en  = accept && (cmd == CMD_LOAD) && !full;
    assign wr.seg = in_seg;

    // Row of cells carrying the query token.
    assign w_tok[0]   = r_inj;
    assign w_first[0] = '0;

    for (genvar gi = 0; gi < MAX_WALLS; gi++) begin : g_cell
        swc_cell #(
            .IDX      (gi),
            .IW       (IW),
            .CW       (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (wr),
            .i_wr_idx(r_count[IW-1:0]),
            .i_count (r_count),
            .i_tok   (w_tok[gi]),
            .i_first (w_first[gi]),
            .o_tok   (w_tok[gi+1]),
            .o_first (w_first[gi+1])
        );
    end

    // Next control state, wall count, token injection and result register.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_inj         = r_inj;
        n_inj.valid   = 1'b0;
        n_res_crossed = r_res_crossed;
        n_res_first   = r_res_first;
        n_res_status  = r_res_status;
        n_m_valid     = r_m_valid && !m_axis_tready;
        n_m_tdata     = r_m_tdata;
        n_m_tuser     = r_m_tuser;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res_crossed = 1'b0;
                    n_res_first   = '0;
                    n_res_status  = 1'b0;
                    n_state       = ST_DONE;
                    case (cmd)
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_LOAD: begin
                            if (full) begin
                                n_res_status = 1'b1;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_QUERY: begin
                            n_inj.valid = 1'b1;
                            n_inj.found = 1'b0;
                            n_inj.seg   = in_seg;
                            n_state     = ST_RUN;
                        end
                        default: begin
                            n_res_status = 1'b0;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (w_tok[MAX_WALLS].valid) begin
                    n_res_crossed = w_tok[MAX_WALLS].found;
                    n_res_first   = w_first[MAX_WALLS];
                    n_state       = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_tdata = {2'b00, COUNT_W'(r_count), FIRST_W'(r_res_first),
                                 r_res_crossed};
                    n_m_tuser = r_res_status;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_inj.valid <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_inj.valid <= n_inj.valid;
            r_m_valid   <= n_m_valid;
        end
        r_inj.found   <= n_inj.found;
        r_inj.seg     <= n_inj.seg;
        r_res_crossed <= n_res_crossed;
        r_res_first   <= n_res_first;
        r_res_status  <= n_res_status;
        r_m_tdata     <= n_m_tdata;
        r_m_tuser     <= n_m_tuser;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

endmodule

FILE: sv/swc_checker.sv
// Port-level checker for the wall crossing check, bound to the top level.
// Depends on swc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swc_checker
    import swc_pkg::*;
#(
    parameter int MAX_WALLS = MAX_WALLS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [1:0]             s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    logic                 out_wait;
    logic                 in_query;
    logic [OUT_TDATA_W:0] out_word;
    logic                 res_crossed;
    logic [FIRST_W-1:0]   res_first;
    logic [COUNT_W-1:0]   res_count;

    // Result fields and handshake conditions seen at the ports.
    assign out_wait    = m_axis_tvalid && !m_axis_tready;
    assign in_query    = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_QUERY);
    assign out_word    = {m_axis_tuser, m_axis_tdata};
    assign res_crossed = m_axis_tdata[0];
    assign res_first   = m_axis_tdata[FIRST_W:1];
    assign res_count   = m_axis_tdata[FIRST_W+COUNT_W:FIRST_W+1];

    // A stalled result holds its value.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, m_axis_tvalid && $stable(out_word))

    // A rejected load never reports a crossing.
    `ASSERT_IMPL(a_full_no_hit, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, !res_crossed && (res_first == '0))

    // Without a crossing the wall index is zero.
    `ASSERT_IMPL(a_miss_index, i_clk, i_rst_n, m_axis_tvalid && !res_crossed, res_first == '0)

    // A crossed wall lies inside the stored table.
    `ASSERT_IMPL(a_hit_in_table, i_clk, i_rst_n, m_axis_tvalid && res_crossed && (MAX_WALLS <= 64), res_first < res_count)

    // A query keeps the block busy for the next cycle.
    `ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, in_query, !s_axis_tready)

endmodule

bind segment_wall_crossing_check swc_checker #(.MAX_WALLS(MAX_WALLS)) u_swc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
